// ----- rtl/line_follow_pid_motor_drive_defines.svh -----
// Assertion macros for the line follower drive. Bodies sample on clk and are
// disabled while rst_n is low; both names must exist where a macro is used.
`ifndef LINE_FOLLOW_PID_MOTOR_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_MOTOR_DRIVE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LFPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfpd assertion failed");
// next-cycle implication
`define LFPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfpd assertion failed");
`else
`define LFPD_ASSERT_IMP(lbl, ante, cons)
`define LFPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/lfpd_pkg.sv -----
package lfpd_pkg;

  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned ERR_W   = 15;
  localparam int unsigned INTEG_W = 15;
  localparam int unsigned DIFF_W  = 16;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned PROD_W  = 41;
  localparam int unsigned ACC_W   = 43;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CORR_W  = ACC_W - FRAC_W;
  localparam int unsigned SPD_W   = CORR_W + 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_KP         = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI         = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD         = 3'd2;
  localparam logic [IDX_W-1:0] REG_SETPOINT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEADBAND   = 3'd5;
  localparam logic [IDX_W-1:0] REG_BASE_SPEED = 3'd6;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 3'd7;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_FWD  = 2'd1;
  localparam dir_t DIR_REV  = 2'd2;

  localparam logic [SPEED_W-1:0] REV_DUTY = 8'd50;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [POS_W-1:0]   setpoint;
    logic [POS_W-1:0]   integral_limit;
    logic [POS_W-1:0]   deadband;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] isum;
    logic signed [DIFF_W-1:0]  diff;
    logic                      inband;
  } err_stage_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [ERR_W-1:0]  err;
    logic                     inband;
  } mul_stage_t;

  typedef struct packed {
    dir_t               dir;
    logic [SPEED_W-1:0] duty;
  } motor_t;

  // Speed limiting plus motor command: negative goes to fixed reverse duty,
  // positive is capped at max, zero is stop.
  function automatic motor_t motor_cmd(input logic signed [SPD_W-1:0] speed,
                                       input logic [SPEED_W-1:0] max_spd);
    motor_t             m;
    logic [SPEED_W-1:0] s;
    if (speed < 0) begin
      m.dir  = DIR_REV;
      m.duty = REV_DUTY;
    end else begin
      if (speed > $signed({{(SPD_W-SPEED_W){1'b0}}, max_spd})) begin
        s = max_spd;
      end else begin
        s = speed[SPEED_W-1:0];
      end
      m.dir  = (s == '0) ? DIR_STOP : DIR_FWD;
      m.duty = s;
    end
    return m;
  endfunction

endpackage

// ----- rtl/line_follow_pid_motor_drive.sv -----
// Line-follower PID motor drive. Each input beat carries one line position
// from the sensor array; each output beat carries error = setpoint - position
// plus a direction (stop/forward/reverse) and PWM duty for each wheel. The
// controller keeps a clamped integral and the last error, forms
// kp*e + ki*I + kd*(e - e_prev) with Q8.16 gains, truncates toward zero and
// drives right = base + corr, left = base - corr, capped at max_speed, with
// any negative speed turned into reverse at duty 50. Inside the deadband both
// wheels run forward at max_speed. Throughput is one beat per clock while out_ready
// does not hold the pipe; an accepted input is loaded into the input register, then
// passes through the error/integral stage, the gain multiply stage and the
// output register. The integral
// and previous-error feedback closes inside the error/integral stage, which
// is what lets a new sample follow every cycle. Every stage has its own valid
// and ready, so bubbles collapse and input keeps flowing while a result waits
// at the output. Gains and limits are written through the cfg port (index
// 0..7: kp, ki, kd, setpoint, integral_limit, deadband, base_speed,
// max_speed), which is always ready; write them only while the pipe is empty.
`include "line_follow_pid_motor_drive_defines.svh"

module line_follow_pid_motor_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfpd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::GAIN_W-1:0]     cfg_data,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lfpd_pkg::POS_W-1:0]      in_line_position,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [lfpd_pkg::ERR_W-1:0] out_line_error,
  output lfpd_pkg::dir_t                  out_right_dir,
  output logic [lfpd_pkg::SPEED_W-1:0]    out_right_duty,
  output lfpd_pkg::dir_t                  out_left_dir,
  output logic [lfpd_pkg::SPEED_W-1:0]    out_left_duty
);
  import lfpd_pkg::*;

  cfg_t       cfg;
  // error/integral stage -> multiplier stage
  logic       es_valid;
  logic       es_ready;
  err_stage_t es_data;
  // multiplier stage -> output stage
  logic       ms_valid;
  logic       ms_ready;
  mul_stage_t ms_data;
  motor_t     right;
  motor_t     left;

  lfpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, error, clamped integral, derivative, deadband test
  lfpd_err_integ u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pos    (in_line_position),
    .out_valid (es_valid),
    .out_ready (es_ready),
    .out_data  (es_data)
  );

  // three gain products in parallel
  lfpd_gain_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (es_valid),
    .in_ready  (es_ready),
    .in_data   (es_data),
    .out_valid (ms_valid),
    .out_ready (ms_ready),
    .out_data  (ms_data)
  );

  // sum, truncate, wheel speeds, motor commands, output register
  lfpd_motor_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (ms_valid),
    .in_ready       (ms_ready),
    .in_data        (ms_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_error (out_line_error),
    .out_right      (right),
    .out_left       (left)
  );

  assign out_right_dir  = right.dir;
  assign out_right_duty = right.duty;
  assign out_left_dir   = left.dir;
  assign out_left_duty  = left.duty;

  // stop exactly when duty is zero
  `LFPD_ASSERT_IMP(a_right_stop, out_valid, (right.dir == DIR_STOP) == (right.duty == '0))
  `LFPD_ASSERT_IMP(a_left_stop, out_valid, (left.dir == DIR_STOP) == (left.duty == '0))
  // reverse always runs at the fixed reverse duty
  `LFPD_ASSERT_IMP(a_right_rev, out_valid && (right.dir == DIR_REV), right.duty == REV_DUTY)
  `LFPD_ASSERT_IMP(a_left_rev, out_valid && (left.dir == DIR_REV), left.duty == REV_DUTY)
  // no result appears without an item in the multiplier stage
  `LFPD_ASSERT_NXT(a_no_phantom, !ms_valid && !out_valid, !out_valid)

endmodule

// ----- rtl/lfpd_cfg_regs.sv -----
module lfpd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfpd_pkg::IDX_W-1:0] cfg_index,
  input  logic [lfpd_pkg::GAIN_W-1:0] cfg_data,
  output lfpd_pkg::cfg_t             cfg
);
  import lfpd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp             <= 24'd65536;
      cfg_r.ki             <= 24'd2621;
      cfg_r.kd             <= 24'd458752;
      cfg_r.setpoint       <= 14'd5000;
      cfg_r.integral_limit <= 14'd5000;
      cfg_r.deadband       <= 14'd750;
      cfg_r.base_speed     <= 8'd200;
      cfg_r.max_speed      <= 8'd250;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP:         cfg_r.kp             <= cfg_data;
        REG_KI:         cfg_r.ki             <= cfg_data;
        REG_KD:         cfg_r.kd             <= cfg_data;
        REG_SETPOINT:   cfg_r.setpoint       <= cfg_data[POS_W-1:0];
        REG_INTEG_LIM:  cfg_r.integral_limit <= cfg_data[POS_W-1:0];
        REG_DEADBAND:   cfg_r.deadband       <= cfg_data[POS_W-1:0];
        REG_BASE_SPEED: cfg_r.base_speed     <= cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:  cfg_r.max_speed      <= cfg_data[SPEED_W-1:0];
      endcase
    end
  end

endmodule

// ----- rtl/lfpd_err_integ.sv -----
module lfpd_err_integ (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfpd_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lfpd_pkg::POS_W-1:0] in_pos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lfpd_pkg::err_stage_t       out_data
);
  import lfpd_pkg::*;

  logic                      a_valid_r;
  logic [POS_W-1:0]          pos_r;
  logic                      b_valid_r;
  err_stage_t                stage_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_r;

  logic                      a_ready;
  logic                      b_ready;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  err_x;
  logic signed [DIFF_W-1:0]  sum;
  logic signed [DIFF_W-1:0]  lim;
  logic signed [DIFF_W-1:0]  db;
  logic signed [DIFF_W-1:0]  clamped;
  err_stage_t                stage_nxt;

  assign b_ready   = !b_valid_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid_r;
  assign out_data  = stage_r;

  always_comb begin
    err   = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, pos_r});
    err_x = DIFF_W'(err);
    lim   = $signed({{(DIFF_W-POS_W){1'b0}}, cfg.integral_limit});
    db    = $signed({{(DIFF_W-POS_W){1'b0}}, cfg.deadband});
    sum   = DIFF_W'(integ_r) + err_x;
    priority if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
    stage_nxt.err    = err;
    stage_nxt.isum   = clamped[INTEG_W-1:0];
    stage_nxt.diff   = err_x - DIFF_W'(prev_r);
    stage_nxt.inband = (err_x >= -db) && (err_x <= db);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      integ_r   <= '0;
      prev_r    <= '0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
        if (a_valid_r) begin
          integ_r <= stage_nxt.isum;
          prev_r  <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      pos_r <= in_pos;
    end
    if (b_ready && a_valid_r) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- rtl/lfpd_gain_mul.sv -----
module lfpd_gain_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfpd_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfpd_pkg::err_stage_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfpd_pkg::mul_stage_t out_data
);
  import lfpd_pkg::*;

  logic       valid_r;
  mul_stage_t stage_r;
  mul_stage_t stage_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = stage_r;

  // three independent signed-by-unsigned products, gains zero-extended
  always_comb begin
    stage_nxt.prod_p = PROD_W'(in_data.err)  * PROD_W'($signed({1'b0, cfg.kp}));
    stage_nxt.prod_i = PROD_W'(in_data.isum) * PROD_W'($signed({1'b0, cfg.ki}));
    stage_nxt.prod_d = PROD_W'(in_data.diff) * PROD_W'($signed({1'b0, cfg.kd}));
    stage_nxt.err    = in_data.err;
    stage_nxt.inband = in_data.inband;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- rtl/lfpd_motor_out.sv -----
module lfpd_motor_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfpd_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lfpd_pkg::mul_stage_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [lfpd_pkg::ERR_W-1:0] out_line_error,
  output lfpd_pkg::motor_t              out_right,
  output lfpd_pkg::motor_t              out_left
);
  import lfpd_pkg::*;

  logic                    valid_r;
  logic signed [ERR_W-1:0] err_r;
  motor_t                  right_r;
  motor_t                  left_r;

  logic signed [ACC_W-1:0] acc;
  logic        [ACC_W-1:0] mag;
  logic signed [CORR_W:0]  corr;
  logic signed [SPD_W-1:0] base_x;
  logic signed [SPD_W-1:0] max_x;
  motor_t                  right_nxt;
  motor_t                  left_nxt;

  assign in_ready       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_line_error = err_r;
  assign out_right      = right_r;
  assign out_left       = left_r;

  always_comb begin
    acc    = ACC_W'(in_data.prod_p) + ACC_W'(in_data.prod_i) + ACC_W'(in_data.prod_d);
    mag    = (acc < 0) ? ACC_W'(-acc) : ACC_W'(acc);
    // truncate toward zero: shift the magnitude, then restore the sign
    corr   = (acc < 0) ? -$signed({1'b0, mag[ACC_W-1:FRAC_W]})
                       :  $signed({1'b0, mag[ACC_W-1:FRAC_W]});
    base_x = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed});
    max_x  = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.max_speed});
    if (in_data.inband) begin
      right_nxt = motor_cmd(max_x, cfg.max_speed);
      left_nxt  = motor_cmd(max_x, cfg.max_speed);
    end else begin
      right_nxt = motor_cmd(base_x + SPD_W'(corr), cfg.max_speed);
      left_nxt  = motor_cmd(base_x - SPD_W'(corr), cfg.max_speed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      err_r   <= in_data.err;
      right_r <= right_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule
